// File: src/tcc_pkg.sv
package tcc_pkg;

	// Operation codes of an input beat
	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// Character and attribute constants
	localparam logic [7:0] NEWLINE_CODE = 8'd10;
	localparam logic [7:0] SPACE_CODE   = 8'h20;
	localparam logic [7:0] BLANK_RESET  = 8'd7;

	// Widest cell address over the supported screen sizes (up to 16384 cells)
	localparam int MAX_AW = 14;

	// Memory action of a queued command
	localparam logic [1:0] K_NOP   = 2'd0;
	localparam logic [1:0] K_WRITE = 2'd1;
	localparam logic [1:0] K_READ  = 2'd2;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] char_code;
		logic [7:0] attribute;
		logic [4:0] read_row;
		logic [6:0] read_col;
	} item_t;

	typedef struct packed {
		logic [15:0] cell_value;
		logic [4:0]  cursor_row;
		logic [6:0]  cursor_col;
		logic        scrolled;
	} result_t;

	// Command from the front end to the back end
	typedef struct packed {
		logic [1:0]        kind;
		logic              blank_all;
		logic              blank_row;
		logic [MAX_AW-1:0] blank_base;
		logic [MAX_AW-1:0] addr;
		logic [15:0]       wdata;
		logic [4:0]        cursor_row;
		logic [6:0]        cursor_col;
		logic              scrolled;
	} cmd_t;

endpackage

// File: src/tcc_ram.sv
module tcc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one word, read one word with registered output
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/tcc_queue.sv
module tcc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tcc_pkg::cmd_t push_cmd,
	input  logic          pop,
	output tcc_pkg::cmd_t head,
	output logic          empty,
	output logic          full
);

	import tcc_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign head  = slot_q[rd_ptr_q];
	assign empty = (count_q == 2'd0);
	assign full  = (count_q == 2'd2);

	// Store the pushed command
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: src/tcc_front.sv
module tcc_front #(
	parameter int COLS = 80,
	parameter int ROWS = 25
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  tcc_pkg::item_t item,
	input  logic           q_full,
	input  logic           init,
	output logic           busy,
	output logic           push,
	output tcc_pkg::cmd_t  push_cmd
);

	import tcc_pkg::*;

	localparam int RW  = $clog2(ROWS);
	localparam int CXW = $clog2(COLS + 1);

	logic [RW-1:0]  cur_y_q;
	logic [CXW-1:0] cur_x_q;
	logic [RW-1:0]  top_q;

	logic [RW-1:0]  y_n;
	logic [CXW-1:0] x_n;
	logic [RW-1:0]  top_n;
	logic [RW-1:0]  top_inc;
	logic           scr;
	cmd_t           cmd_n;

	// Physical row of a visible row in the row ring
	function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] top,
			input logic [RW-1:0] r);
		int s;
		s = int'(top) + int'(r);
		if (s >= ROWS) begin
			s = s - ROWS;
		end
		return RW'(s);
	endfunction

	function automatic int row_base(input logic [RW-1:0] r);
		return int'(r) * COLS;
	endfunction

	assign busy    = q_full | init;
	assign push    = start & ~busy;
	assign top_inc = (top_q == RW'(ROWS - 1)) ? '0 : top_q + 1'b1;

	// Classify the beat and update the cursor
	always_comb begin
		y_n   = cur_y_q;
		x_n   = cur_x_q;
		top_n = top_q;
		scr   = 1'b0;
		cmd_n = '0;
		cmd_n.kind = K_NOP;
		case (item.op)
			OP_PUT: begin
				if (item.char_code == NEWLINE_CODE || cur_x_q == CXW'(COLS)) begin
					if (cur_y_q == RW'(ROWS - 1)) begin
						scr              = 1'b1;
						top_n            = top_inc;
						cmd_n.blank_row  = 1'b1;
						cmd_n.blank_base = MAX_AW'(row_base(top_q));
					end else begin
						y_n = cur_y_q + 1'b1;
					end
					x_n = '0;
				end
				if (item.char_code != NEWLINE_CODE) begin
					cmd_n.kind  = K_WRITE;
					cmd_n.addr  = MAX_AW'(row_base(phys_row(top_n, y_n)) + int'(x_n));
					cmd_n.wdata = {item.attribute, item.char_code};
					x_n         = x_n + 1'b1;
				end
			end
			OP_READ: begin
				if (int'(item.read_row) < ROWS && int'(item.read_col) < COLS) begin
					cmd_n.kind = K_READ;
					cmd_n.addr = MAX_AW'(row_base(phys_row(top_q, RW'(item.read_row)))
						+ int'(item.read_col));
				end
			end
			OP_CLEAR: begin
				y_n             = '0;
				x_n             = '0;
				top_n           = '0;
				cmd_n.blank_all = 1'b1;
			end
			default: ;
		endcase
		cmd_n.cursor_row = 5'(y_n);
		cmd_n.cursor_col = 7'(x_n);
		cmd_n.scrolled   = scr;
	end

	assign push_cmd = cmd_n;

	// Hold cursor and ring offset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_y_q <= '0;
			cur_x_q <= '0;
			top_q   <= '0;
		end else if (push) begin
			cur_y_q <= y_n;
			cur_x_q <= x_n;
			top_q   <= top_n;
		end
	end

endmodule

// File: src/tcc_back.sv
module tcc_back #(
	parameter int COLS = 80,
	parameter int ROWS = 25
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       blank_color,
	input  tcc_pkg::cmd_t    head,
	input  logic             empty,
	output logic             pop,
	output logic             init,
	output logic             result_valid,
	output tcc_pkg::result_t result
);

	import tcc_pkg::*;

	localparam int N  = ROWS * COLS;
	localparam int AW = $clog2(N);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SWEEP  = 2'd1;
	localparam logic [1:0] ST_EXEC   = 2'd2;
	localparam logic [1:0] ST_RDWAIT = 2'd3;

	logic [1:0]    state_q;
	logic          init_q;
	logic [AW-1:0] sw_addr_q;
	logic [AW-1:0] sw_last_q;
	cmd_t          cmd_q;
	logic          valid_q;
	result_t       res_q;

	logic          we;
	logic [AW-1:0] waddr;
	logic [15:0]   wdata;
	logic          re;
	logic [15:0]   rdata;

	assign pop          = (state_q == ST_IDLE) && !empty;
	assign init         = init_q;
	assign result_valid = valid_q;
	assign result       = res_q;

	// Drive the screen store ports
	always_comb begin
		we    = 1'b0;
		waddr = sw_addr_q;
		wdata = {blank_color, SPACE_CODE};
		re    = 1'b0;
		case (state_q)
			ST_SWEEP: we = 1'b1;
			ST_EXEC: begin
				if (cmd_q.kind == K_WRITE) begin
					we    = 1'b1;
					waddr = AW'(cmd_q.addr);
					wdata = cmd_q.wdata;
				end
				re = (cmd_q.kind == K_READ);
			end
			default: ;
		endcase
	end

	tcc_ram #(
		.WIDTH(16),
		.DEPTH(N)
	) u_screen (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(AW'(cmd_q.addr)),
		.rdata(rdata)
	);

	// Take a command from the queue
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head;
		end
	end

	// Sequence blanking sweeps, writes and reads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_SWEEP;
			init_q    <= 1'b1;
			sw_addr_q <= '0;
			sw_last_q <= AW'(N - 1);
			valid_q   <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						if (head.blank_all) begin
							sw_addr_q <= '0;
							sw_last_q <= AW'(N - 1);
							state_q   <= ST_SWEEP;
						end else if (head.blank_row) begin
							sw_addr_q <= AW'(head.blank_base);
							sw_last_q <= AW'(head.blank_base) + AW'(COLS - 1);
							state_q   <= ST_SWEEP;
						end else begin
							state_q <= ST_EXEC;
						end
					end
				end
				ST_SWEEP: begin
					if (sw_addr_q == sw_last_q) begin
						init_q  <= 1'b0;
						state_q <= init_q ? ST_IDLE : ST_EXEC;
					end else begin
						sw_addr_q <= sw_addr_q + 1'b1;
					end
				end
				ST_EXEC: begin
					if (cmd_q.kind == K_READ) begin
						state_q <= ST_RDWAIT;
					end else begin
						valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_RDWAIT: begin
					valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Register the result beat
	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC || state_q == ST_RDWAIT) begin
			res_q.cell_value <= (state_q == ST_RDWAIT) ? rdata : 16'd0;
			res_q.cursor_row <= cmd_q.cursor_row;
			res_q.cursor_col <= cmd_q.cursor_col;
			res_q.scrolled   <= cmd_q.scrolled;
		end
	end

endmodule

// File: src/text_console_cursor_scroll.sv
// Channel   Handshake                   Payload
// ------    --------------------------  ------------------------------------
// command   start, busy (out)           item (op, char_code, attribute, row, col)
// result    result_valid strobe         result (cell_value, cursor, scrolled)
// config    cfg_valid, cfg_ready (out)  cfg_data (blank_color)
//
// A put or clear beat takes the back end through idle and execute states, a read through
// idle, execute and read-wait; a scroll adds the blanking of one row and a clear that of
// the whole screen, through the single write port of the screen store. The result strobe
// is registered as execute ends for a put and as read-wait ends for a read, after any
// blanking. After reset the whole store is blanked with busy high and cfg_ready low. A
// two-entry command queue lets new beats in while the back end sweeps a row or a clear;
// busy rises when it is full. Results are strobed for one cycle and never held.
module text_console_cursor_scroll #(
	parameter int COLS = 80,
	parameter int ROWS = 25
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  tcc_pkg::item_t   item,
	output logic             result_valid,
	output tcc_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [7:0]       cfg_data
);

	import tcc_pkg::*;

	logic [7:0] blank_color_q;
	logic       push;
	cmd_t       push_cmd;
	cmd_t       head;
	logic       pop;
	logic       empty;
	logic       full;
	logic       init;

	// Hold off config beats while the reset sweep blanks the store
	assign cfg_ready = ~init;

	// Hold the blank attribute
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_color_q <= BLANK_RESET;
		end else if (cfg_valid && cfg_ready) begin
			blank_color_q <= cfg_data;
		end
	end

	tcc_front #(
		.COLS(COLS),
		.ROWS(ROWS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.item    (item),
		.q_full  (full),
		.init    (init),
		.busy    (busy),
		.push    (push),
		.push_cmd(push_cmd)
	);

	tcc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.head    (head),
		.empty   (empty),
		.full    (full)
	);

	tcc_back #(
		.COLS(COLS),
		.ROWS(ROWS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.blank_color (blank_color_q),
		.head        (head),
		.empty       (empty),
		.pop         (pop),
		.init        (init),
		.result_valid(result_valid),
		.result      (result)
	);

endmodule

// File: tb/sv/text_console_cursor_scroll_tb.sv
module text_console_cursor_scroll_tb;
	import tcc_pkg::*;

	localparam int COLS = 80;
	localparam int ROWS = 25;
	localparam int BEATS_PER_PHASE = 155;
	localparam int NUM_PHASES = 6;
	// op code that the block must ignore
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	item_t      cmd_beat = '0;
	logic       result_valid;
	result_t    res_beat;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_data = 8'd0;

	// Console mirror: ring of rows, cursor and blank attribute
	logic [15:0] screen_mirror [ROWS*COLS];
	int unsigned cur_y;
	int unsigned cur_x;
	int unsigned top_ofs;
	logic [7:0]  blank_attr;

	item_t   pending_beats [$];
	result_t expected_results [$];
	logic    beat_taken = 1'b0;
	int      idle_left = 0;
	bit      quiet_tail = 1'b0;
	int      beats_queued = 0;
	int      mismatch_count = 0;
	int      cycle_count = 0;
	int      cycle_budget = 4 * ROWS * COLS;

	text_console_cursor_scroll #(
		.COLS(COLS),
		.ROWS(ROWS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(cmd_beat),
		.result_valid(result_valid),
		.result(res_beat),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic int unsigned cell_index(int unsigned row, int unsigned col);
		return ((top_ofs + row) % ROWS) * COLS + col;
	endfunction

	function automatic void blank_mirror_row(int unsigned prow);
		for (int c = 0; c < COLS; c++)
			screen_mirror[prow*COLS + c] = {blank_attr, SPACE_CODE};
	endfunction

	function automatic void clear_mirror();
		top_ofs = 0;
		for (int r = 0; r < ROWS; r++)
			blank_mirror_row(r);
		cur_y = 0;
		cur_x = 0;
	endfunction

	// Move to column 0 of the next row; return 1 when the screen scrolls
	function automatic logic next_line();
		logic rolled;
		rolled = 1'b0;
		if (cur_y >= ROWS - 1) begin
			blank_mirror_row(top_ofs);
			top_ofs = (top_ofs + 1) % ROWS;
			rolled = 1'b1;
		end else begin
			cur_y++;
		end
		cur_x = 0;
		return rolled;
	endfunction

	function automatic result_t console_step(item_t b);
		result_t r;
		r = '0;
		case (b.op)
			OP_PUT: begin
				if (b.char_code == NEWLINE_CODE) begin
					r.scrolled = next_line();
				end else begin
					// deferred wrap: a pending wrap resolves on the next printable
					if (cur_x >= COLS)
						r.scrolled = next_line();
					screen_mirror[cell_index(cur_y, cur_x)] = {b.attribute, b.char_code};
					cur_x++;
				end
			end
			OP_READ: begin
				if (b.read_row < ROWS && b.read_col < COLS)
					r.cell_value = screen_mirror[cell_index(32'(b.read_row),
						32'(b.read_col))];
			end
			OP_CLEAR: begin
				clear_mirror();
			end
			default: begin
			end
		endcase
		r.cursor_row = cur_y[4:0];
		r.cursor_col = cur_x[6:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 100)
			$display("MISMATCH cycle %0d: %s", cycle_count, what);
	endtask

	function automatic item_t make_beat(logic [1:0] op, logic [7:0] ch, logic [7:0] attr,
			logic [4:0] row, logic [6:0] col);
		item_t b;
		b.op = op;
		b.char_code = ch;
		b.attribute = attr;
		b.read_row = row;
		b.read_col = col;
		return b;
	endfunction

	task automatic add_beat(item_t b);
		pending_beats.push_back(b);
		if (b.op != OP_UNUSED)
			beats_queued++;
		cycle_budget += (b.op == OP_CLEAR) ? ROWS*COLS + 16 : COLS + 16;
	endtask

	task automatic add_put(logic [7:0] ch);
		add_beat(make_beat(OP_PUT, ch, 8'($urandom_range(0, 255)),
			5'($urandom_range(0, 31)), 7'($urandom_range(0, 127))));
	endtask

	task automatic add_read(logic [4:0] row, logic [6:0] col);
		add_beat(make_beat(OP_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			row, col));
	endtask

	function automatic logic [7:0] printable();
		logic [7:0] ch;
		ch = 8'($urandom_range(0, 255));
		if (ch == NEWLINE_CODE)
			ch = SPACE_CODE;
		return ch;
	endfunction

	task automatic add_random_chunk();
		int pick;
		int len;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			// one line of text, often long enough to hit the deferred wrap
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: len = $urandom_range(0, 20);
				5, 6, 7: len = $urandom_range(COLS - 4, COLS + 4);
				default: len = $urandom_range(0, COLS + 10);
			endcase
			for (int i = 0; i < len; i++)
				add_put(printable());
			if ($urandom_range(0, 9) < 7)
				add_put(NEWLINE_CODE);
		end else if (pick < 65) begin
			repeat ($urandom_range(1, 4)) begin
				if ($urandom_range(0, 99) < 85)
					add_read(5'($urandom_range(0, ROWS - 1)),
						7'($urandom_range(0, COLS - 1)));
				else
					add_read(5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
			end
		end else if (pick < 80) begin
			// run of newlines to push text off the top
			repeat ($urandom_range(1, 30))
				add_put(NEWLINE_CODE);
		end else if (pick < 91) begin
			add_put(8'($urandom_range(0, 255)));
		end else if (pick < 97) begin
			add_beat(make_beat(OP_UNUSED, 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
				7'($urandom_range(0, 127))));
		end else begin
			add_beat(make_beat(OP_CLEAR, 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
				7'($urandom_range(0, 127))));
		end
	endtask

	// Hold until every queued beat is taken and every result is back
	task automatic drain();
		while (pending_beats.size() != 0 || start || expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_blank_color(input logic [7:0] value);
		drain();
		// let any row blanking still in flight finish
		cycle_budget += 2 * ROWS * COLS + 64;
		repeat (2 * ROWS * COLS) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		blank_attr = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
		cfg_data <= 8'($urandom_range(0, 255));
	endtask

	// Capture accepted beats and predict their results
	always @(posedge clk) begin
		beat_taken <= arst_n && start && !busy;
		if (arst_n && start && !busy)
			expected_results.push_back(console_step(cmd_beat));
	end

	// Drive the next beat at the falling edge, with random idle bursts
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || beat_taken) begin
			if (idle_left > 0) begin
				start <= 1'b0;
				idle_left <= idle_left - 1;
			end else if (pending_beats.size() > 0) begin
				start <= 1'b1;
				cmd_beat <= pending_beats.pop_front();
				if (!quiet_tail && $urandom_range(0, 5) == 0)
					idle_left <= $urandom_range(1, 4);
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Check each result strobe against the oldest prediction
	always @(posedge clk) begin : result_monitor
		result_t want;
		if (arst_n && result_valid) begin
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result %h with nothing expected", res_beat));
			end else begin
				want = expected_results.pop_front();
				if (res_beat.cell_value !== want.cell_value)
					report_mismatch($sformatf("cell_value %h, expected %h",
						res_beat.cell_value, want.cell_value));
				if (res_beat.cursor_row !== want.cursor_row)
					report_mismatch($sformatf("cursor_row %0d, expected %0d",
						res_beat.cursor_row, want.cursor_row));
				if (res_beat.cursor_col !== want.cursor_col)
					report_mismatch($sformatf("cursor_col %0d, expected %0d",
						res_beat.cursor_col, want.cursor_col));
				if (res_beat.scrolled !== want.scrolled)
					report_mismatch($sformatf("scrolled %b, expected %b",
						res_beat.scrolled, want.scrolled));
			end
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 4 * cycle_budget + 20000) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		logic [7:0] color;
		blank_attr = BLANK_RESET;
		clear_mirror();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: field extremes, every op, and the corner cases
		add_read(5'd0, 7'd0);
		add_beat(make_beat(OP_PUT, 8'h00, 8'h00, 5'd0, 7'd0));
		add_beat(make_beat(OP_PUT, 8'hFF, 8'hFF, 5'd31, 7'd127));
		add_read(5'd0, 7'd0);
		add_read(5'd0, 7'd1);
		add_put(NEWLINE_CODE);
		add_read(5'(ROWS - 1), 7'(COLS - 1));
		add_read(5'(ROWS), 7'd0);
		add_read(5'd0, 7'(COLS));
		add_read(5'd31, 7'd127);
		add_beat(make_beat(OP_UNUSED, 8'hFF, 8'hFF, 5'd31, 7'd127));
		add_beat(make_beat(OP_UNUSED, NEWLINE_CODE, 8'h00, 5'd0, 7'd0));
		add_beat(make_beat(OP_CLEAR, 8'h00, 8'h00, 5'd0, 7'd0));
		add_read(5'd0, 7'd0);
		add_beat(make_beat(OP_PUT, 8'h41, 8'h1E, 5'd0, 7'd0));
		add_read(5'd0, 7'd0);
		add_read(5'd1, 7'd0);

		// Random phases, each under its own blank attribute
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: color = 8'h00;
				1: color = 8'hFF;
				3: color = 8'h5A;
				default: color = 8'($urandom_range(0, 255));
			endcase
			write_blank_color(color);
			if (p == NUM_PHASES - 1)
				quiet_tail = 1'b1;
			beats_queued = 0;
			while (beats_queued < BEATS_PER_PHASE)
				add_random_chunk();
		end

		drain();
		repeat (ROWS * COLS + 4 * COLS) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
